[rtl/sed_pkg.sv]
package sed_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       burst_end;
    } sed_in_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       message_last;
        logic       message_empty;
    } sed_out_t;

    typedef struct packed {
        logic [1:0] start_len;
        logic [7:0] start_first;
        logic [7:0] start_second;
        logic [1:0] end_len;
        logic [7:0] end_first;
        logic [7:0] end_second;
    } sed_cfg_t;

    // One queue entry: the results caused by one accepted byte (one or two)
    typedef struct packed {
        logic     two;
        sed_out_t first;
        sed_out_t second;
    } sed_ent_t;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_LEN    = 3'd0,
        REG_START_FIRST  = 3'd1,
        REG_START_SECOND = 3'd2,
        REG_END_LEN      = 3'd3,
        REG_END_FIRST    = 3'd4,
        REG_END_SECOND   = 3'd5
    } sed_reg_e;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    function automatic sed_out_t mk_res(logic [7:0] b, logic last, logic empty);
        sed_out_t r;
        r.payload_byte  = b;
        r.message_last  = last;
        r.message_empty = empty;
        return r;
    endfunction

endpackage

[rtl/sed_front.sv]
module sed_front #(
    parameter logic [1:0] LEN_LIM = 2'd2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  sed_pkg::sed_cfg_t cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  sed_pkg::sed_in_t  s_data,
    input  logic              q_full,
    output logic              q_push,
    output sed_pkg::sed_ent_t q_ent
);
    import sed_pkg::*;

    logic       in_msg_reg, in_msg_next;
    logic       sm_reg, sm_next;
    logic       eh_reg, eh_next;
    logic       ps_reg, ps_next;
    logic [7:0] hb_reg, hb_next;

    logic [1:0] sl, el;
    logic [1:0] cnt;
    sed_out_t   res [2];
    logic       done;
    logic       go;
    logic [7:0] b;
    logic       be;
    logic       acc;

    assign s_ready = ~q_full;
    assign acc     = s_valid & s_ready;

    always_comb begin
        b  = s_data.rx_byte;
        be = s_data.burst_end;
        sl = (cfg.start_len > LEN_LIM) ? LEN_LIM : cfg.start_len;
        el = (cfg.end_len > LEN_LIM) ? LEN_LIM : cfg.end_len;

        in_msg_next = in_msg_reg;
        sm_next     = sm_reg;
        eh_next     = eh_reg;
        ps_next     = ps_reg;
        hb_next     = hb_reg;
        cnt         = 2'd0;
        res[0]      = '0;
        res[1]      = '0;
        done        = 1'b0;
        go          = 1'b1;

        // hunt for the start delimiter
        if (!in_msg_reg) begin
            if (sl == 2'd0) begin
                in_msg_next = 1'b1;
                sm_next     = 1'b0;
                ps_next     = 1'b0;
                eh_next     = 1'b0;
            end else begin
                done = (sl == 2'd1) ? (b == cfg.start_first)
                                    : (sm_reg && (b == cfg.start_second));
                go   = 1'b0;
                if (!done) begin
                    sm_next = (sl == 2'd2) && (b == cfg.start_first);
                end else begin
                    sm_next     = 1'b0;
                    in_msg_next = 1'b1;
                    ps_next     = 1'b0;
                    eh_next     = 1'b0;
                    if ((el == 2'd0) && be) begin
                        res[0]      = mk_res(8'd0, 1'b1, 1'b1);
                        cnt         = 2'd1;
                        in_msg_next = 1'b0;
                    end
                end
            end
        end

        if (go) begin
            case (el)
                2'd0: begin
                    eh_next = 1'b0;
                    if (ps_next) begin
                        res[cnt[0]] = mk_res(hb_next, 1'b0, 1'b0);
                        cnt         = cnt + 2'd1;
                        ps_next     = 1'b0;
                    end
                    res[cnt[0]] = mk_res(b, be, 1'b0);
                    cnt         = cnt + 2'd1;
                    if (be) begin
                        in_msg_next = 1'b0;
                    end
                end
                2'd1: begin
                    eh_next = 1'b0;
                    if (b == cfg.end_first) begin
                        res[0]      = ps_next ? mk_res(hb_next, 1'b1, 1'b0)
                                              : mk_res(8'd0, 1'b1, 1'b1);
                        cnt         = 2'd1;
                        in_msg_next = 1'b0;
                        ps_next     = 1'b0;
                    end else begin
                        if (ps_next) begin
                            res[0] = mk_res(hb_next, 1'b0, 1'b0);
                            cnt    = 2'd1;
                        end
                        hb_next = b;
                        ps_next = 1'b1;
                    end
                end
                default: begin
                    if (eh_next && (b == cfg.end_second)) begin
                        res[0]      = ps_next ? mk_res(hb_next, 1'b1, 1'b0)
                                              : mk_res(8'd0, 1'b1, 1'b1);
                        cnt         = 2'd1;
                        in_msg_next = 1'b0;
                        ps_next     = 1'b0;
                        eh_next     = 1'b0;
                    end else begin
                        // held end byte turned out to be data
                        if (eh_next) begin
                            if (ps_next) begin
                                res[cnt[0]] = mk_res(hb_next, 1'b0, 1'b0);
                                cnt         = cnt + 2'd1;
                            end
                            hb_next = cfg.end_first;
                            ps_next = 1'b1;
                            eh_next = 1'b0;
                        end
                        if (b == cfg.end_first) begin
                            eh_next = 1'b1;
                        end else begin
                            if (ps_next) begin
                                res[cnt[0]] = mk_res(hb_next, 1'b0, 1'b0);
                                cnt         = cnt + 2'd1;
                            end
                            hb_next = b;
                            ps_next = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    assign q_push       = acc && (cnt != 2'd0);
    assign q_ent.two    = (cnt == 2'd2);
    assign q_ent.first  = res[0];
    assign q_ent.second = res[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_msg_reg <= 1'b0;
            sm_reg     <= 1'b0;
            eh_reg     <= 1'b0;
            ps_reg     <= 1'b0;
        end else if (acc) begin
            in_msg_reg <= in_msg_next;
            sm_reg     <= sm_next;
            eh_reg     <= eh_next;
            ps_reg     <= ps_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            hb_reg <= hb_next;
        end
    end

endmodule

[rtl/sed_queue.sv]
module sed_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  sed_pkg::sed_ent_t push_ent,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output sed_pkg::sed_ent_t pop_ent
);
    import sed_pkg::*;

    localparam logic [QCNT_W-1:0] QFULL = QCNT_W'(QDEPTH);

    sed_ent_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wp_reg, wp_next;
    logic [QPTR_W-1:0]   rp_reg, rp_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    assign full      = (cnt_reg == QFULL);
    assign not_empty = (cnt_reg != '0);
    assign pop_ent   = mem_reg[rp_reg];

    always_comb begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= push_ent;
        end
    end

endmodule

[rtl/sed_back.sv]
module sed_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  sed_pkg::sed_ent_t q_ent,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output sed_pkg::sed_out_t m_data
);
    import sed_pkg::*;

    logic     ov_reg, ov_next;
    sed_out_t od_reg, od_next;
    logic     pv_reg, pv_next;
    sed_out_t pd_reg, pd_next;
    logic     load;

    assign load    = ~ov_reg | m_ready;
    assign q_pop   = load & ~pv_reg & q_valid;
    assign m_valid = ov_reg;
    assign m_data  = od_reg;

    always_comb begin
        ov_next = ov_reg;
        od_next = od_reg;
        pv_next = pv_reg;
        pd_next = pd_reg;
        if (load) begin
            if (pv_reg) begin
                // send the second result of the entry
                ov_next = 1'b1;
                od_next = pd_reg;
                pv_next = 1'b0;
            end else if (q_valid) begin
                ov_next = 1'b1;
                od_next = q_ent.first;
                pv_next = q_ent.two;
                pd_next = q_ent.second;
            end else begin
                ov_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
            pv_reg <= 1'b0;
        end else begin
            ov_reg <= ov_next;
            pv_reg <= pv_next;
        end
    end

    always_ff @(posedge aclk) begin
        od_reg <= od_next;
        pd_reg <= pd_next;
    end

endmodule

[rtl/stx_etx_deframer.sv]
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_valid / s_ready  | s_data:  rx_byte, burst_end
// m_      | out       | m_valid / m_ready  | m_data:  payload_byte, message_last,
//         |           |                    |          message_empty
// cfg_    | in        | cfg_we             | cfg_index, cfg_wdata (no read-back)
//
// One byte is accepted per cycle while the queue is not full; a byte is classified in the cycle it is taken.
// Results leave through a 4-entry queue and an output register, one result per
// cycle while m_ready is high, so the two results of one byte leave one after the other.
// A result is registered in the queue and then in the output register before it shows on m_.
// s_ready drops only when the queue is full; m_ready stalls back up into it.
// aresetn is synchronous: it clears the framing state, the queue, the config registers and the valid flags.
module stx_etx_deframer #(
    parameter int DELIM_MAX = 2
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  sed_pkg::sed_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output sed_pkg::sed_out_t                 m_data,
    input  logic                              cfg_we,
    input  logic [sed_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sed_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import sed_pkg::*;

    localparam logic [1:0] LEN_LIM = (DELIM_MAX < 2) ? 2'(DELIM_MAX) : 2'd2;

    sed_cfg_t cfg_reg, cfg_next;
    logic     q_push, q_full, q_pop, q_valid;
    sed_ent_t q_in, q_out;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_START_LEN:    cfg_next.start_len    = cfg_wdata[1:0];
                REG_START_FIRST:  cfg_next.start_first  = cfg_wdata;
                REG_START_SECOND: cfg_next.start_second = cfg_wdata;
                REG_END_LEN:      cfg_next.end_len      = cfg_wdata[1:0];
                REG_END_FIRST:    cfg_next.end_first    = cfg_wdata;
                REG_END_SECOND:   cfg_next.end_second   = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    sed_front #(
        .LEN_LIM (LEN_LIM)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_ent   (q_in)
    );

    sed_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_ent  (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_ent   (q_out)
    );

    sed_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ent   (q_out),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[rtl/sed_checker.sv]
module sed_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input sed_pkg::sed_out_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // an empty message is a single closing result with a zero byte
    a_empty_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.message_empty |->
            m_data.message_last && (m_data.payload_byte == 8'd0))
        else $error("malformed empty result");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown right after reset");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");

endmodule

bind stx_etx_deframer sed_checker u_sed_checker (.*);
